@@ rtl/core/mbsp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// MIDI byte stream parser package
// Shared types and constants for the parser core and its decoder.
// ----------------------------------------------------------------------------
package mbsp_pkg;

  localparam int unsigned KindW  = 4;
  localparam int unsigned ChanW  = 4;
  localparam int unsigned DataW  = 7;
  localparam int unsigned CountW = 32;
  localparam int unsigned PhaseW = 4;

  typedef logic [KindW-1:0]  kind_t;
  typedef logic [ChanW-1:0]  chan_t;
  typedef logic [DataW-1:0]  data_t;
  typedef logic [CountW-1:0] count_t;
  typedef logic [PhaseW-1:0] phase_t;

  // Parse phase codes: for voice kind k, 2k+1 waits for the first data byte
  // and 2k+2 waits for the second.
  localparam phase_t PHASE_WAIT   = 4'd0;
  localparam phase_t PHASE_UNUSED = 4'd15;

  // Voice kinds that take a single data byte.
  localparam logic [2:0] KIND_PROG    = 3'd4;
  localparam logic [2:0] KIND_CHAN_AT = 3'd5;

  // First real-time event code (0xF8 maps here).
  localparam kind_t KIND_RT_BASE = 4'd7;

  // Parser state carried between items.
  typedef struct packed {
    phase_t phase;
    chan_t  channel;
    data_t  held;
  } parse_state_t;

  // Decoded event, minus the message count.
  typedef struct packed {
    kind_t kind;
    chan_t channel;
    data_t first_data;
    data_t second_data;
  } event_t;

endpackage
`default_nettype wire

@@ rtl/core/mbsp_decode.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// MIDI byte decoder
// Next-state and event logic for one received byte under running status.
// ----------------------------------------------------------------------------
module mbsp_decode
  import mbsp_pkg::*;
(
  input  wire logic [7:0]   rx_byte,
  input  wire parse_state_t state_cur,
  output parse_state_t      state_nxt,
  output logic              emit,
  output event_t            evt
);

  logic       is_rt;
  logic       is_syscom;
  logic [2:0] kind_odd;
  logic [2:0] kind_even;
  data_t      data_byte;

  assign is_rt     = (rx_byte[7:3] == 5'b11111);
  assign is_syscom = (rx_byte[7:4] == 4'hF);
  assign data_byte = rx_byte[DataW-1:0];
  assign kind_odd  = state_cur.phase[3:1];
  assign kind_even = state_cur.phase[3:1] - 3'd1;

  always_comb begin
    state_nxt = state_cur;
    emit      = 1'b0;
    evt       = '0;
    if (is_rt) begin
      // real-time: report at once, leave the partial message alone
      emit     = 1'b1;
      evt.kind = KIND_RT_BASE + kind_t'(rx_byte[2:0]);
    end else if (is_syscom) begin
      // system common: ignore
    end else if (rx_byte[7]) begin
      state_nxt.channel = rx_byte[3:0];
      state_nxt.phase   = {rx_byte[6:4], 1'b1};
    end else if (state_cur.phase == PHASE_WAIT || state_cur.phase == PHASE_UNUSED) begin
      // stray data byte: drop it
      state_nxt.held = '0;
    end else if (state_cur.phase[0]) begin
      if (kind_odd == KIND_PROG || kind_odd == KIND_CHAN_AT) begin
        emit            = 1'b1;
        evt.kind        = kind_t'(kind_odd);
        evt.channel     = state_cur.channel;
        evt.first_data  = data_byte;
        state_nxt.held  = '0;
      end else begin
        state_nxt.held  = data_byte;
        state_nxt.phase = state_cur.phase + 4'd1;
      end
    end else begin
      emit            = 1'b1;
      evt.kind        = kind_t'(kind_even);
      evt.channel     = state_cur.channel;
      evt.first_data  = state_cur.held;
      evt.second_data = data_byte;
      state_nxt.held  = '0;
      // hold the message type for running status
      state_nxt.phase = state_cur.phase - 4'd1;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/midi_byte_stream_parser.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// MIDI byte stream parser
// Turns received MIDI bytes into voice and real-time events.
// ----------------------------------------------------------------------------
// Input channel in_*: one received byte per item in in_tdata[7:0].
// Output channel out_*: one event per item; out_tuser carries the event kind,
// out_tdata the channel, both data bytes and the running message count.
// Status bytes, system common bytes, stray data bytes and the first data byte of
// a three-byte message produce no event; all but system common bytes only update
// the parse state. Each event is registered in the output register, or in the
// skid register when an earlier event still waits. Throughput: one byte per cycle
// while in_tready is high; the parse state and the message counter do not limit it.
// When the receiver stalls, the output register holds its event and one more
// event goes into a skid register; in_tready falls only once that is full.
// Reset (rst_n low, synchronous) clears the parse state, channel, held data
// byte, message counter and the valid flags of both output registers; no
// events are pending.
// ----------------------------------------------------------------------------
module midi_byte_stream_parser
  import mbsp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] rx_byte
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [55:0]      out_tdata,  // [3:0] channel, [10:4] first_data,
                                       // [17:11] second_data,
                                       // [49:18] message_count, [55:50] zero
  output logic [3:0]       out_tuser   // [3:0] event_kind
);

  parse_state_t state_r, state_nxt;
  count_t       count_r, count_nxt;
  logic         emit;
  event_t       evt;
  logic         accept;
  logic         res_valid;
  logic         out_free;

  logic         out_valid_r;
  event_t       out_evt_r;
  count_t       out_count_r;
  logic         skid_valid_r;
  event_t       skid_evt_r;
  count_t       skid_count_r;

  mbsp_decode u_decode (
    .rx_byte   (in_tdata),
    .state_cur (state_r),
    .state_nxt (state_nxt),
    .emit      (emit),
    .evt       (evt)
  );

  assign in_tready = !skid_valid_r;
  assign accept    = in_tvalid && in_tready;
  assign res_valid = accept && emit;
  assign count_nxt = count_r + count_t'(1);
  assign out_free  = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
      count_r <= '0;
    end else if (accept) begin
      state_r <= state_nxt;
      if (emit) begin
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_r) begin
        // drain skid first to keep order
        out_valid_r  <= 1'b1;
        out_evt_r    <= skid_evt_r;
        out_count_r  <= skid_count_r;
        skid_valid_r <= res_valid;
        skid_evt_r   <= evt;
        skid_count_r <= count_nxt;
      end else begin
        out_valid_r <= res_valid;
        out_evt_r   <= evt;
        out_count_r <= count_nxt;
      end
    end else if (res_valid) begin
      skid_valid_r <= 1'b1;
      skid_evt_r   <= evt;
      skid_count_r <= count_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_evt_r.kind;
  assign out_tdata  = {6'd0, out_count_r, out_evt_r.second_data,
                       out_evt_r.first_data, out_evt_r.channel};

endmodule
`default_nettype wire
